// ===== hdl/rpn_pkg.sv =====
package rpn_pkg;

  localparam int unsigned VAR_COUNT = 26;
  localparam logic [63:0] SIGN_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef logic [3:0] op_t;
  localparam op_t OP_PUSH  = 4'd0;
  localparam op_t OP_ADD   = 4'd1;
  localparam op_t OP_SUB   = 4'd2;
  localparam op_t OP_MUL   = 4'd3;
  localparam op_t OP_DIV   = 4'd4;
  localparam op_t OP_MOD   = 4'd5;
  localparam op_t OP_STORE = 4'd6;
  localparam op_t OP_LOADV = 4'd7;
  localparam op_t OP_LOADL = 4'd8;
  localparam op_t OP_PRINT = 4'd9;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_PRINTED = 3'd1;
  localparam status_t ST_EMPTY   = 3'd2;
  localparam status_t ST_FULL    = 3'd3;
  localparam status_t ST_DIVZERO = 3'd4;
  localparam status_t ST_UNKNOWN = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_POPB, S_GETB, S_POPA, S_GETA, S_VRD, S_MUL, S_DIV, S_PUSH, S_DONE
  } state_t;

  function automatic status_t raise(input status_t cur, input status_t code);
    raise = (cur == ST_OK) ? code : cur;
  endfunction

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    magnitude = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] signed_sat(input logic neg, input logic [63:0] mag,
                                             input logic ovf);
    if (neg) begin
      signed_sat = (ovf || mag > SIGN_MIN) ? SIGN_MIN : (64'd0 - mag);
    end else begin
      signed_sat = (ovf || mag > MAX_POS) ? MAX_POS : mag;
    end
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      add_sat = a[63] ? SIGN_MIN : MAX_POS;
    end else begin
      add_sat = s;
    end
  endfunction

  function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) begin
      sub_sat = a[63] ? SIGN_MIN : MAX_POS;
    end else begin
      sub_sat = d;
    end
  endfunction

endpackage

// ===== hdl/rpn_stack_calculator.sv =====
// RPN stack calculator: one parsed token per request on the in_ channel
// (in_op, in_number_value, in_var_index), one result per request on the
// out_ channel (out_status, out_result_value). Values are signed Q31.32.
// Both channels hand over a request when valid is high and stall is low.
// The block works on one token at a time; in_stall stays high from accept
// until the result has been loaded into the output register.
// The path from accept to out_valid runs through the registered read of the
// operand stack and the arithmetic units, by op through these states:
//   unknown op: done; push / load last: push, done; load variable: read,
//   push, done; print / store / zero divisor: pop, get, done; add / sub:
//   two pops, push, done; multiply: four 32x32 partial products, one per cycle;
//   divide / remainder: radix-2 divider, 96 steps.
// A new token is accepted only after the last one has left the done state.
// Reset clears the stack pointer, the variable valid bits (variables read
// as zero until stored), the last printed value and the output valid flag.
// The stack memory itself is not cleared; only written entries are read.
// When out_stall is high the finished result waits in the output register;
// the next token may be accepted and worked on, and it holds in its final
// state until the output register is free.
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic [63:0] in_number_value,
  input  logic [4:0]  in_var_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_result_value
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);

  rpn_pkg::state_t  state_r, state_nxt;
  logic [SPW-1:0]   sp_r, sp_nxt;
  rpn_pkg::op_t     op_r;
  logic [63:0]      num_r;
  logic [4:0]       vi_r;
  logic [63:0]      a_r, a_nxt;
  logic [63:0]      b_r, b_nxt;
  logic [63:0]      val_r, val_nxt;
  rpn_pkg::status_t st_r, st_nxt;
  logic [63:0]      res_r, res_nxt;
  logic [63:0]      last_r, last_nxt;
  logic             popok_r, popok_nxt;
  logic             out_valid_r;
  rpn_pkg::status_t out_status_r;
  logic [63:0]      out_res_r;

  // operand stack memory
  logic [63:0]      stk_mem [STACK_DEPTH];
  logic [63:0]      stk_q;
  logic             stk_rd;
  logic [AW-1:0]    stk_raddr;
  logic             stk_wr;
  logic [AW-1:0]    stk_waddr;

  // variable file with per-entry valid bits
  logic [63:0]      var_mem [rpn_pkg::VAR_COUNT];
  logic [rpn_pkg::VAR_COUNT-1:0] var_vld_r;
  logic [63:0]      var_q;
  logic             var_vld_q;
  logic             var_wr;

  logic             accept;
  logic             out_free;
  logic             pop_value_ok;
  logic [63:0]      pop_value;
  logic [63:0]      pop_mag;
  logic [63:0]      b_mag;
  logic             vi_ok;
  logic             in_vi_ok;

  logic             mul_start;
  logic             mul_done;
  logic             div_start;
  logic             div_done;
  logic [63:0]      mul_q;
  logic             mul_ovf;
  logic [95:0]      div_dvd;
  logic [63:0]      div_dvs;
  logic [63:0]      div_quot;
  logic [63:0]      div_rem;
  logic             div_ovf;
  logic [63:0]      mod_val;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != rpn_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign pop_value = popok_r ? stk_q : 64'd0;
  assign pop_mag   = rpn_pkg::magnitude(pop_value);
  assign b_mag     = rpn_pkg::magnitude(b_r);
  assign vi_ok     = (vi_r < 5'(rpn_pkg::VAR_COUNT));
  assign in_vi_ok  = (in_var_index < 5'(rpn_pkg::VAR_COUNT));
  assign pop_value_ok = (sp_r != '0);

  // remainder carries the sign of the dividend, integer part only
  assign mod_val = {a_r[63] ? (32'd0 - div_rem[31:0]) : div_rem[31:0], 32'd0};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpn_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op)
            rpn_pkg::OP_PUSH, rpn_pkg::OP_LOADL: state_nxt = rpn_pkg::S_PUSH;
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
            rpn_pkg::OP_DIV, rpn_pkg::OP_MOD:     state_nxt = rpn_pkg::S_POPB;
            rpn_pkg::OP_STORE, rpn_pkg::OP_PRINT: state_nxt = rpn_pkg::S_POPA;
            rpn_pkg::OP_LOADV:                    state_nxt = rpn_pkg::S_VRD;
            default:                              state_nxt = rpn_pkg::S_DONE;
          endcase
        end
      end
      rpn_pkg::S_POPB: state_nxt = rpn_pkg::S_GETB;
      rpn_pkg::S_GETB: begin
        if ((op_r == rpn_pkg::OP_DIV && pop_value == 64'd0) ||
            (op_r == rpn_pkg::OP_MOD && pop_mag[63:32] == 32'd0)) begin
          state_nxt = rpn_pkg::S_DONE;
        end else begin
          state_nxt = rpn_pkg::S_POPA;
        end
      end
      rpn_pkg::S_POPA: state_nxt = rpn_pkg::S_GETA;
      rpn_pkg::S_GETA: begin
        case (op_r)
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: state_nxt = rpn_pkg::S_PUSH;
          rpn_pkg::OP_MUL:                  state_nxt = rpn_pkg::S_MUL;
          rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: state_nxt = rpn_pkg::S_DIV;
          default:                          state_nxt = rpn_pkg::S_DONE;
        endcase
      end
      rpn_pkg::S_VRD: state_nxt = rpn_pkg::S_PUSH;
      rpn_pkg::S_MUL: if (mul_done) state_nxt = rpn_pkg::S_PUSH;
      rpn_pkg::S_DIV: if (div_done) state_nxt = rpn_pkg::S_PUSH;
      rpn_pkg::S_PUSH: state_nxt = rpn_pkg::S_DONE;
      rpn_pkg::S_DONE: if (out_free) state_nxt = rpn_pkg::S_IDLE;
      default: state_nxt = rpn_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    sp_nxt    = sp_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    popok_nxt = popok_r;
    stk_rd    = 1'b0;
    stk_raddr = AW'(sp_r - SPW'(1));
    stk_wr    = 1'b0;
    stk_waddr = AW'(sp_r);
    var_wr    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    div_dvd   = {pop_mag, 32'd0};
    div_dvs   = b_mag;
    case (state_r)
      rpn_pkg::S_IDLE: begin
        if (accept) begin
          st_nxt  = rpn_pkg::ST_OK;
          res_nxt = 64'd0;
          if (in_op == rpn_pkg::OP_PUSH) val_nxt = in_number_value;
          if (in_op == rpn_pkg::OP_LOADL) val_nxt = last_r;
          if (in_op > rpn_pkg::OP_PRINT) st_nxt = rpn_pkg::ST_UNKNOWN;
        end
      end
      rpn_pkg::S_POPB, rpn_pkg::S_POPA: begin
        // pop: read the top entry now, the data lands next cycle
        popok_nxt = pop_value_ok;
        if (pop_value_ok) begin
          stk_rd = 1'b1;
          sp_nxt = sp_r - SPW'(1);
        end else begin
          st_nxt = rpn_pkg::raise(st_r, rpn_pkg::ST_EMPTY);
        end
      end
      rpn_pkg::S_GETB: begin
        b_nxt = pop_value;
        if ((op_r == rpn_pkg::OP_DIV && pop_value == 64'd0) ||
            (op_r == rpn_pkg::OP_MOD && pop_mag[63:32] == 32'd0)) begin
          st_nxt = rpn_pkg::raise(st_r, rpn_pkg::ST_DIVZERO);
        end
      end
      rpn_pkg::S_GETA: begin
        a_nxt = pop_value;
        case (op_r)
          rpn_pkg::OP_ADD: val_nxt = rpn_pkg::add_sat(pop_value, b_r);
          rpn_pkg::OP_SUB: val_nxt = rpn_pkg::sub_sat(pop_value, b_r);
          rpn_pkg::OP_MUL: mul_start = 1'b1;
          rpn_pkg::OP_DIV: div_start = 1'b1;
          rpn_pkg::OP_MOD: begin
            div_start = 1'b1;
            div_dvd = {64'd0, pop_mag[63:32]};
            div_dvs = {32'd0, b_mag[63:32]};
          end
          rpn_pkg::OP_STORE: var_wr = vi_ok;
          rpn_pkg::OP_PRINT: begin
            last_nxt = pop_value;
            res_nxt  = pop_value;
            st_nxt   = rpn_pkg::raise(st_r, rpn_pkg::ST_PRINTED);
          end
          default: ;
        endcase
      end
      rpn_pkg::S_VRD: val_nxt = (vi_ok && var_vld_q) ? var_q : 64'd0;
      rpn_pkg::S_MUL: begin
        if (mul_done) val_nxt = rpn_pkg::signed_sat(a_r[63] ^ b_r[63], mul_q, mul_ovf);
      end
      rpn_pkg::S_DIV: begin
        if (div_done) begin
          if (op_r == rpn_pkg::OP_MOD) begin
            val_nxt = mod_val;
          end else begin
            val_nxt = rpn_pkg::signed_sat(a_r[63] ^ b_r[63], div_quot, div_ovf);
          end
        end
      end
      rpn_pkg::S_PUSH: begin
        // drop the value when the stack is full
        if (sp_r < SPW'(STACK_DEPTH)) begin
          stk_wr = 1'b1;
          sp_nxt = sp_r + SPW'(1);
        end else begin
          st_nxt = rpn_pkg::raise(st_r, rpn_pkg::ST_FULL);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpn_pkg::S_IDLE;
      sp_r        <= '0;
      last_r      <= 64'd0;
      var_vld_r   <= '0;
      out_valid_r <= 1'b0;
      popok_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      last_r  <= last_nxt;
      popok_r <= popok_nxt;
      if (var_wr) var_vld_r[vi_r] <= 1'b1;
      if (state_r == rpn_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      num_r <= in_number_value;
      vi_r  <= in_var_index;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    val_r <= val_nxt;
    st_r  <= st_nxt;
    res_r <= res_nxt;
    if (state_r == rpn_pkg::S_DONE && out_free) begin
      out_status_r <= st_r;
      out_res_r    <= res_r;
    end
  end

  // stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (stk_wr) stk_mem[stk_waddr] <= (op_r == rpn_pkg::OP_PUSH) ? num_r : val_r;
    if (stk_rd) stk_q <= stk_mem[stk_raddr];
  end

  // variable file: write on store, registered read on load
  always_ff @(posedge clk) begin
    if (var_wr) var_mem[vi_r] <= pop_value;
    if (accept && in_op == rpn_pkg::OP_LOADV && in_vi_ok) begin
      var_q     <= var_mem[in_var_index];
      var_vld_q <= var_vld_r[in_var_index];
    end else if (accept) begin
      var_vld_q <= 1'b0;
    end
  end

  rpn_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mag_a (pop_mag),
    .mag_b (b_mag),
    .done  (mul_done),
    .mag_q (mul_q),
    .ovf   (mul_ovf)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem),
    .ovf      (div_ovf)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_res_r;

endmodule

// ===== hdl/rpn_mul.sv =====
module rpn_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         mag_a,
  input  logic [63:0]         mag_b,
  output logic                done,
  output logic [63:0]         mag_q,
  output logic                ovf
);

  logic [2:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [63:0]  pp_r;
  logic [1:0]   psel_r;
  logic         pvld_r;
  logic [127:0] acc_r;
  logic [31:0]  op_x;
  logic [31:0]  op_y;
  logic [127:0] pp_sh;

  // pick one 32x32 partial product per cycle
  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin op_x = mag_a[31:0];  op_y = mag_b[31:0];  end
      2'd1: begin op_x = mag_a[31:0];  op_y = mag_b[63:32]; end
      2'd2: begin op_x = mag_a[63:32]; op_y = mag_b[31:0];  end
      default: begin op_x = mag_a[63:32]; op_y = mag_b[63:32]; end
    endcase
  end

  always_comb begin
    case (psel_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'd0};
      default: pp_sh = {32'd0, pp_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pvld_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
        pvld_r <= 1'b0;
      end else if (busy_r) begin
        pvld_r <= (cnt_r < 3'd4);
        cnt_r  <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= 128'd0;
    end else if (busy_r) begin
      pp_r   <= 64'(op_x * op_y);
      psel_r <= cnt_r[1:0];
      if (pvld_r) acc_r <= acc_r + pp_sh;
    end
  end

  assign done  = done_r;
  assign mag_q = acc_r[95:32];
  assign ovf   = (acc_r[127:96] != 32'd0);

endmodule

// ===== hdl/rpn_div.sv =====
module rpn_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [95:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem,
  output logic        ovf
);

  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [95:0] dvd_r;
  logic [63:0] dvs_r;
  logic [63:0] rem_r;
  logic [63:0] q_r;
  logic        ovf_r;
  logic [64:0] trial;
  logic        qbit;
  logic [63:0] rem_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[95]};
    qbit  = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? 64'(trial - {1'b0, dvs_r}) : trial[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd95) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= 64'd0;
      q_r   <= 64'd0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[94:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[62:0], qbit};
      if (q_r[63]) ovf_r <= 1'b1;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;
  assign ovf  = ovf_r;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 128;
  localparam int unsigned RANDOM_REQS = 1490;
  localparam int unsigned STALL_LIMIT = 20000;

  // Idling modes: sender/receiver idle percentages per phase
  typedef enum int {MODE_SEND_IDLE, MODE_RECV_IDLE, MODE_NONE} idle_mode_t;

  typedef struct {
    rpn_pkg::status_t status;
    logic [63:0]      value;
  } calc_result_t;

  typedef struct {
    rpn_pkg::op_t     op;
    logic [63:0]      num;
    logic [4:0]       vidx;
    logic             typed;    // expected result typed in below
    rpn_pkg::status_t status;
    logic [63:0]      value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_op = '0;
  logic [63:0] in_number_value = '0;
  logic [4:0]  in_var_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_result_value;

  always #1 clk = ~clk;

  rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_number_value(in_number_value), .in_var_index(in_var_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_result_value(out_result_value)
  );

  // Predictor state, mirrored from the block
  logic [63:0]      calc_stack [DEPTH];
  int unsigned      calc_depth;
  logic [63:0]      calc_vars [rpn_pkg::VAR_COUNT];
  logic [63:0]      calc_last;
  rpn_pkg::status_t calc_status;

  calc_result_t pending_results [$];
  int unsigned  mismatches;
  bit           failed;
  idle_mode_t   idle_mode;
  bit           hold_receiver;
  int unsigned  idle_cycles;

  function automatic void note_error(rpn_pkg::status_t code);
    if (calc_status == rpn_pkg::ST_OK) calc_status = code;
  endfunction

  function automatic void calc_push(logic [63:0] v);
    if (calc_depth < DEPTH) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end else begin
      note_error(rpn_pkg::ST_FULL);
    end
  endfunction

  function automatic logic [63:0] calc_pop();
    if (calc_depth > 0) begin
      calc_depth--;
      return calc_stack[calc_depth];
    end
    note_error(rpn_pkg::ST_EMPTY);
    return '0;
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] clamp_signed(logic neg, logic [63:0] mag, logic ovf);
    if (neg) return (ovf || mag > rpn_pkg::SIGN_MIN) ? rpn_pkg::SIGN_MIN : -mag;
    return (ovf || mag > rpn_pkg::MAX_POS) ? rpn_pkg::MAX_POS : mag;
  endfunction

  // Q31.32 product: full 128-bit magnitude product, keep bits 95:32, saturate on higher bits
  function automatic logic [63:0] q_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    return clamp_signed(a[63] ^ b[63], p[95:32], |p[127:96]);
  endfunction

  // Q31.32 quotient: (|a| << 32) / |b|, truncated toward zero
  function automatic logic [63:0] q_quotient(logic [63:0] a, logic [63:0] b);
    logic [95:0] q;
    q = {abs64(a), 32'd0} / {32'd0, abs64(b)};
    return clamp_signed(a[63] ^ b[63], q[63:0], |q[95:64]);
  endfunction

  // Saturating add/sub written independently of the package helpers
  function automatic logic [63:0] add_result(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? rpn_pkg::SIGN_MIN : rpn_pkg::MAX_POS;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sub_result(logic [63:0] a, logic [63:0] b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return d[64] ? rpn_pkg::SIGN_MIN : rpn_pkg::MAX_POS;
    return d[63:0];
  endfunction

  function automatic calc_result_t evaluate_token(rpn_pkg::op_t op, logic [63:0] num,
                                                  logic [4:0] vidx);
    calc_result_t r;
    logic [63:0] a, b, xi, yi, m;
    r.value = '0;
    calc_status = rpn_pkg::ST_OK;
    case (op)
      rpn_pkg::OP_PUSH: calc_push(num);
      rpn_pkg::OP_ADD: begin
        b = calc_pop(); a = calc_pop(); calc_push(add_result(a, b));
      end
      rpn_pkg::OP_SUB: begin
        b = calc_pop(); a = calc_pop(); calc_push(sub_result(a, b));
      end
      rpn_pkg::OP_MUL: begin
        b = calc_pop(); a = calc_pop(); calc_push(q_product(a, b));
      end
      rpn_pkg::OP_DIV: begin
        b = calc_pop();
        if (b == 0) begin
          note_error(rpn_pkg::ST_DIVZERO);
        end else begin
          a = calc_pop(); calc_push(q_quotient(a, b));
        end
      end
      rpn_pkg::OP_MOD: begin
        b = calc_pop();
        yi = abs64(b) >> 32;
        if (yi == 0) begin
          note_error(rpn_pkg::ST_DIVZERO);
        end else begin
          a = calc_pop();
          xi = abs64(a) >> 32;
          m = (xi % yi) << 32;
          calc_push(a[63] ? -m : m);
        end
      end
      rpn_pkg::OP_STORE: begin
        a = calc_pop();
        if (vidx < rpn_pkg::VAR_COUNT) calc_vars[vidx] = a;
      end
      rpn_pkg::OP_LOADV: calc_push(vidx < rpn_pkg::VAR_COUNT ? calc_vars[vidx] : 64'd0);
      rpn_pkg::OP_LOADL: calc_push(calc_last);
      rpn_pkg::OP_PRINT: begin
        a = calc_pop();
        calc_last = a;
        r.value = a;
        note_error(rpn_pkg::ST_PRINTED);
      end
      default: note_error(rpn_pkg::ST_UNKNOWN);
    endcase
    r.status = calc_status;
    return r;
  endfunction

  // Receiver: stall at random per mode, or hold off when asked
  always @(negedge clk) begin
    if (hold_receiver)
      out_stall <= 1'b1;
    else if (idle_mode == MODE_RECV_IDLE)
      out_stall <= ($urandom_range(99) < 24);
    else if (idle_mode == MODE_SEND_IDLE)
      out_stall <= ($urandom_range(99) < 66);
    else
      out_stall <= 1'b0;
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk) begin
    calc_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d value %h", out_status, out_result_value);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status || out_result_value !== exp_r.value) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d value %h, got status %0d value %h",
                     exp_r.status, exp_r.value, out_status, out_result_value);
        end
      end
    end
  end

  // Watchdog: count cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one request and hold it until accepted; check a typed expectation
  task automatic send_token(rpn_pkg::op_t op, logic [63:0] num, logic [4:0] vidx,
                            bit typed = 1'b0,
                            rpn_pkg::status_t t_status = rpn_pkg::ST_OK,
                            logic [63:0] t_value = '0);
    calc_result_t r;
    if (idle_mode == MODE_SEND_IDLE) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end else if (idle_mode == MODE_RECV_IDLE) begin
      while ($urandom_range(99) < 66) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_number_value <= num;
    in_var_index <= vidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = evaluate_token(op, num, vidx);
    if (typed && (r.status !== t_status || r.value !== t_value)) begin
      failed = 1'b1;
      $display("directed row disagrees: op %0d expected status %0d value %h",
               op, t_status, t_value);
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // Random operand: corners, small integers and raw noise
  function automatic logic [63:0] random_number();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return {32'($signed($urandom_range(40)) - 20), $urandom};
      2: return {32'($signed($urandom_range(2000)) - 1000), 32'd0};
      3: return $urandom_range(3) == 0 ? rpn_pkg::SIGN_MIN : rpn_pkg::MAX_POS;
      4: return '0;
      default: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'd0, $urandom};
    endcase
  endfunction

  function automatic rpn_pkg::op_t random_op();
    int unsigned pick;
    pick = $urandom_range(99);
    if (calc_depth < 3 && pick < 60) return rpn_pkg::OP_PUSH;
    if (calc_depth > DEPTH - 3 && pick < 50) return rpn_pkg::OP_PRINT;
    if (pick < 28) return rpn_pkg::OP_PUSH;
    if (pick < 36) return rpn_pkg::OP_ADD;
    if (pick < 43) return rpn_pkg::OP_SUB;
    if (pick < 52) return rpn_pkg::OP_MUL;
    if (pick < 58) return rpn_pkg::OP_DIV;
    if (pick < 63) return rpn_pkg::OP_MOD;
    if (pick < 70) return rpn_pkg::OP_STORE;
    if (pick < 77) return rpn_pkg::OP_LOADV;
    if (pick < 81) return rpn_pkg::OP_LOADL;
    if (pick < 96) return rpn_pkg::OP_PRINT;
    return rpn_pkg::op_t'($urandom_range(15, 10));
  endfunction

  stim_row_t directed [] = '{
    // print and pop on an empty stack after reset
    '{rpn_pkg::OP_PRINT, 64'd0, 5'd0, 1'b1, rpn_pkg::ST_EMPTY, 64'd0},
    '{rpn_pkg::OP_ADD,   64'd0, 5'd0, 1'b1, rpn_pkg::ST_EMPTY, 64'd0},
    '{rpn_pkg::OP_PRINT, 64'd0, 5'd0, 1'b1, rpn_pkg::ST_PRINTED, 64'd0},
    '{rpn_pkg::OP_LOADV, 64'd0, 5'd25, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_LOADL, 64'd0, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{4'd15,             64'd0, 5'd31, 1'b1, rpn_pkg::ST_UNKNOWN, 64'd0},
    '{4'd10,             64'd0, 5'd0, 1'b1, rpn_pkg::ST_UNKNOWN, 64'd0},
    // saturating add and subtract of the extremes
    '{rpn_pkg::OP_PUSH,  rpn_pkg::MAX_POS, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_PUSH,  rpn_pkg::MAX_POS, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_ADD,   64'd0, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_PRINT, 64'd0, 5'd0, 1'b1, rpn_pkg::ST_PRINTED, rpn_pkg::MAX_POS},
    '{rpn_pkg::OP_PUSH,  rpn_pkg::SIGN_MIN, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_PUSH,  64'h0000_0001_0000_0000, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_SUB,   64'd0, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_PRINT, 64'd0, 5'd0, 1'b1, rpn_pkg::ST_PRINTED, rpn_pkg::SIGN_MIN},
    // divide by zero keeps the dividend
    '{rpn_pkg::OP_PUSH,  64'h0000_0007_0000_0000, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_PUSH,  64'd0, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_DIV,   64'd0, 5'd0, 1'b1, rpn_pkg::ST_DIVZERO, 64'd0},
    // remainder with a fraction-only divisor
    '{rpn_pkg::OP_PUSH,  64'h0000_0000_8000_0000, 5'd0, 1'b1, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_MOD,   64'd0, 5'd0, 1'b1, rpn_pkg::ST_DIVZERO, 64'd0},
    // store out of range discards, store in range and reload
    '{rpn_pkg::OP_STORE, 64'd0, 5'd31, 1'b0, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_PUSH,  64'hFFFF_FFFD_0000_0000, 5'd0, 1'b0, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_STORE, 64'd0, 5'd0, 1'b0, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_LOADV, 64'd0, 5'd0, 1'b0, rpn_pkg::ST_OK, 64'd0},
    '{rpn_pkg::OP_MUL,   64'd0, 5'd0, 1'b0, rpn_pkg::ST_OK, 64'd0}
  };

  initial begin
    logic [63:0] num;
    for (int i = 0; i < DEPTH; i++) calc_stack[i] = '0;
    for (int i = 0; i < rpn_pkg::VAR_COUNT; i++) calc_vars[i] = '0;
    calc_depth = 0;
    calc_last = '0;
    mismatches = 0;
    failed = 1'b0;
    idle_cycles = 0;
    hold_receiver = 1'b0;
    idle_mode = MODE_NONE;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (directed[i])
      send_token(directed[i].op, directed[i].num, directed[i].vidx,
                 directed[i].typed, directed[i].status, directed[i].value);
    drain_results();

    // Mod overflow corner and a clean stack
    send_token(rpn_pkg::OP_PUSH, rpn_pkg::SIGN_MIN, 5'd0);
    send_token(rpn_pkg::OP_PUSH, 64'hFFFF_FFFF_0000_0000, 5'd0);
    send_token(rpn_pkg::OP_MOD, 64'd0, 5'd0);
    while (calc_depth > 0) send_token(rpn_pkg::OP_PRINT, 64'd0, 5'd0);

    // Hold off the receiver for a long stretch while requests pile up
    hold_receiver = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_receiver = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_token(rpn_pkg::OP_PUSH, random_number(), 5'd0);
    join
    // Fill the stack to overflow, then pause until every result is in
    while (calc_depth < DEPTH + 2) begin
      send_token(rpn_pkg::OP_PUSH, random_number(), 5'($urandom_range(31)));
      if (calc_depth == DEPTH) send_token(rpn_pkg::OP_PUSH, random_number(), 5'd0);
      if (calc_depth == DEPTH) break;
    end
    send_token(rpn_pkg::OP_LOADL, 64'd0, 5'd0);
    drain_results();

    // Random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      idle_mode = idle_mode_t'(phase);
      for (int i = 0; i < RANDOM_REQS / 3; i++) begin
        num = random_number();
        send_token(random_op(), num, 5'($urandom_range(31)));
      end
    end
    idle_mode = MODE_NONE;

    drain_results();
    if (!failed && mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
